@@ rtl/signal_stats_accumulator_defines.svh @@
// Assertion macros shared by the checker of the signal statistics block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SIGNAL_STATS_ACCUMULATOR_DEFINES_SVH
`define SIGNAL_STATS_ACCUMULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssa_checker: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssa_checker: assertion failed");

`endif

@@ rtl/ssa_pkg.sv @@
// Package of the signal statistics block: transaction types, sequencer states
// and the control struct between the top level and the divide/root engine.
// No dependencies.
package ssa_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RESULT_W    = 16;
  localparam int COUNT_OUT_W = 17;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } ssa_in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] max_sample;
    logic signed [RESULT_W-1:0] min_sample;
    logic signed [RESULT_W-1:0] mean_value;
    logic [RESULT_W-1:0]        rms_value;
    logic [COUNT_OUT_W-1:0]     sample_count;
    logic                       overflow;
  } ssa_out_t;

  typedef enum logic [1:0] {
    S_ACC,
    S_START,
    S_CALC
  } ssa_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MEAN,
    E_MSQ,
    E_ROOT,
    E_DONE
  } ssa_eng_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } ssa_ctl_t;

endpackage

@@ rtl/ssa_divsqrt.sv @@
// Iterative engine for the end of a record: mean by restoring division, mean square
// by restoring division and RMS by a digit-by-digit square root, all on one subtractor.
// Depends on ssa_pkg.
module ssa_divsqrt import ssa_pkg::*; #(
  parameter int CNT_W = 17
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssa_ctl_t                          ctl,
  input  logic signed [SAMPLE_W+CNT_W-1:0]  sum,
  input  logic [2*SAMPLE_W+CNT_W-3:0]       sumsq,
  input  logic [CNT_W-1:0]                  count,
  output logic                              done,
  output logic [RESULT_W-1:0]               mean,
  output logic [RESULT_W-1:0]               rms
);

  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int SQ_W   = 2*SAMPLE_W - 2 + CNT_W;
  localparam int ROOT_W = 2*SAMPLE_W - 1;
  localparam int UW     = (CNT_W + 1 > 2*SAMPLE_W) ? CNT_W + 1 : 2*SAMPLE_W;
  localparam int IW     = $clog2(SQ_W + 1);
  localparam int PAD_W  = SQ_W - SUM_W;

  ssa_eng_state_t      state_r, state_nxt;
  logic [SQ_W-1:0]     num_r, num_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [ROOT_W-1:0]   x_r, x_nxt;
  logic [ROOT_W-1:0]   res_r, res_nxt;
  logic [ROOT_W-1:0]   bit_r, bit_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [RESULT_W-1:0] mean_r, mean_nxt;

  logic [CNT_W:0]      shifted;
  logic [ROOT_W:0]     root_trial;
  logic [UW-1:0]       op_a, op_b;
  logic [UW:0]         diff;
  logic                ge;
  logic [SQ_W-1:0]     quot;
  logic [CNT_W-1:0]    rem_div;
  logic [SUM_W-1:0]    sum_mag;
  logic [RESULT_W-1:0] q_low, mean_calc;

  always_comb begin
    shifted    = {rem_r, num_r[SQ_W-1]};
    root_trial = {1'b0, res_r} + {1'b0, bit_r};
    if (state_r == E_ROOT) begin
      op_a = UW'(x_r);
      op_b = UW'(root_trial);
    end else begin
      op_a = UW'(shifted);
      op_b = UW'(den_r);
    end
    diff      = {1'b0, op_a} - {1'b0, op_b};
    ge        = ~diff[UW];
    quot      = {num_r[SQ_W-2:0], ge};
    rem_div   = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    sum_mag   = sum[SUM_W-1] ? (SUM_W'(~sum) + SUM_W'(1)) : SUM_W'(sum);
    q_low     = quot[RESULT_W-1:0];
    mean_calc = neg_r ? (~q_low + RESULT_W'(1)) : q_low;
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    sq_nxt    = sq_r;
    x_nxt     = x_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    idx_nxt   = idx_r;
    mean_nxt  = mean_r;
    done      = 1'b0;
    case (state_r)
      E_IDLE: begin
        if (ctl.start) begin
          num_nxt   = {sum_mag, PAD_W'(0)};
          rem_nxt   = '0;
          den_nxt   = count;
          neg_nxt   = sum[SUM_W-1];
          sq_nxt    = sumsq;
          idx_nxt   = IW'(SUM_W);
          state_nxt = E_MEAN;
        end
      end
      E_MEAN: begin
        num_nxt = quot;
        rem_nxt = rem_div;
        idx_nxt = idx_r - IW'(1);
        if (idx_r == IW'(1)) begin
          mean_nxt  = mean_calc;
          num_nxt   = sq_r;
          rem_nxt   = '0;
          idx_nxt   = IW'(SQ_W);
          state_nxt = E_MSQ;
        end
      end
      E_MSQ: begin
        num_nxt = quot;
        rem_nxt = rem_div;
        idx_nxt = idx_r - IW'(1);
        if (idx_r == IW'(1)) begin
          x_nxt     = quot[ROOT_W-1:0];
          res_nxt   = '0;
          bit_nxt   = {1'b1, (ROOT_W-1)'(0)};
          idx_nxt   = IW'(SAMPLE_W);
          state_nxt = E_ROOT;
        end
      end
      E_ROOT: begin
        if (ge) begin
          x_nxt   = diff[ROOT_W-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        idx_nxt = idx_r - IW'(1);
        if (idx_r == IW'(1)) begin
          state_nxt = E_DONE;
        end
      end
      E_DONE: begin
        done = 1'b1;
        if (ctl.ack) begin
          state_nxt = E_IDLE;
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    sq_r   <= sq_nxt;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    mean_r <= mean_nxt;
  end

  assign mean = mean_r;
  assign rms  = res_r[RESULT_W-1:0];

endmodule

@@ rtl/signal_stats_accumulator.sv @@
// Top level of the signal statistics block: running sum, sum of squares, count,
// maximum and minimum per record, with the end-of-record math in ssa_divsqrt.
// Depends on ssa_pkg and ssa_divsqrt.
//
//   channel  ports                          direction  contents
//   in       in_valid, in_stall, in_data    sink       sample, last
//   out      out_valid, out_stall, out_data source     max, min, mean, rms, count, overflow
//
// A sample without the last mark is taken every cycle while in_stall is low.
// The closing sample is followed by the mean division, the mean square division and
// the square root on the shared subtractor, in that order.
// Input is stalled during that time; the result register lets a new record start
// while the previous result still waits. Reset clears all accumulators at once.
module signal_stats_accumulator import ssa_pkg::*; #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ssa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ssa_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2*SAMPLE_W - 2 + CNT_W;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, (SAMPLE_W-1)'(0)};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  ssa_state_t                 state_r, state_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_h_r;
  logic [SQ_W-1:0]            sumsq_r, sumsq_h_r;
  logic [CNT_W-1:0]           cnt_r, cnt_h_r;
  logic signed [SAMPLE_W-1:0] max_r, max_h_r;
  logic signed [SAMPLE_W-1:0] min_r, min_h_r;
  logic                       ovf_r, ovf_h_r;
  logic                       out_valid_r, out_valid_nxt;
  ssa_out_t                   out_data_r;

  logic                       accept;
  logic                       full;
  logic signed [SAMPLE_W-1:0] s;
  logic [SAMPLE_W-1:0]        mag;
  logic [2*SAMPLE_W-1:0]      square;
  logic signed [SUM_W-1:0]    sum_u;
  logic [SQ_W-1:0]            sumsq_u;
  logic [CNT_W-1:0]           cnt_u;
  logic signed [SAMPLE_W-1:0] max_u, min_u;
  logic                       ovf_u;
  logic                       load_out;
  ssa_ctl_t                   ctl;
  logic                       eng_done;
  logic [RESULT_W-1:0]        eng_mean, eng_rms;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign in_stall = (state_r != S_ACC);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s       = in_data.sample;
    mag     = s[SAMPLE_W-1] ? (SAMPLE_W'(~s) + SAMPLE_W'(1)) : SAMPLE_W'(s);
    square  = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
    full    = (cnt_r == CNT_W'(MAX_SAMPLES));
    sum_u   = full ? sum_r : sum_r + SUM_W'(s);
    sumsq_u = full ? sumsq_r : sumsq_r + SQ_W'(square);
    cnt_u   = full ? cnt_r : cnt_r + CNT_W'(1);
    max_u   = (!full && (s > max_r)) ? s : max_r;
    min_u   = (!full && (s < min_r)) ? s : min_r;
    ovf_u   = ovf_r | full;
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    load_out  = 1'b0;
    case (state_r)
      S_ACC: begin
        if (accept && in_data.last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        ctl.start = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (eng_done && (!out_valid_r || !out_stall)) begin
          ctl.ack   = 1'b1;
          load_out  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      cnt_r       <= '0;
      max_r       <= SAMPLE_MIN;
      min_r       <= SAMPLE_MAX;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (in_data.last) begin
          sum_r   <= '0;
          sumsq_r <= '0;
          cnt_r   <= '0;
          max_r   <= SAMPLE_MIN;
          min_r   <= SAMPLE_MAX;
          ovf_r   <= 1'b0;
        end else begin
          sum_r   <= sum_u;
          sumsq_r <= sumsq_u;
          cnt_r   <= cnt_u;
          max_r   <= max_u;
          min_r   <= min_u;
          ovf_r   <= ovf_u;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last) begin
      sum_h_r   <= sum_u;
      sumsq_h_r <= sumsq_u;
      cnt_h_r   <= cnt_u;
      max_h_r   <= max_u;
      min_h_r   <= min_u;
      ovf_h_r   <= ovf_u;
    end
    if (load_out) begin
      out_data_r.max_sample   <= max_h_r;
      out_data_r.min_sample   <= min_h_r;
      out_data_r.mean_value   <= eng_mean;
      out_data_r.rms_value    <= eng_rms;
      out_data_r.sample_count <= cnt_ext[COUNT_OUT_W-1:0];
      out_data_r.overflow     <= ovf_h_r;
    end
  end

  assign cnt_ext = (CNT_W+COUNT_OUT_W)'(cnt_h_r);

  ssa_divsqrt #(
    .CNT_W (CNT_W)
  ) u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sum   (sum_h_r),
    .sumsq (sumsq_h_r),
    .count (cnt_h_r),
    .done  (eng_done),
    .mean  (eng_mean),
    .rms   (eng_rms)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/ssa_checker.sv @@
// Port-level assertions for the signal statistics block, bound to its top level.
// Depends on ssa_pkg and signal_stats_accumulator_defines.svh.
`include "signal_stats_accumulator_defines.svh"

module ssa_checker import ssa_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ssa_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input ssa_out_t out_data
);

  logic signed [RESULT_W-1:0] hi_v, lo_v, avg_v;
  logic [RESULT_W-1:0]        avg_mag;

  assign hi_v    = out_data.max_sample;
  assign lo_v    = out_data.min_sample;
  assign avg_v   = out_data.mean_value;
  assign avg_mag = avg_v[RESULT_W-1] ? (~avg_v + RESULT_W'(1)) : avg_v;

  `SSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SSA_ASSERT_SAME(a_min_le_max, out_valid, lo_v <= hi_v)
  `SSA_ASSERT_SAME(a_mean_range, out_valid, (lo_v <= avg_v) && (avg_v <= hi_v))
  `SSA_ASSERT_SAME(a_rms_ge_mean, out_valid, out_data.rms_value >= avg_mag)
  `SSA_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && in_data.last, in_stall)

endmodule

bind signal_stats_accumulator ssa_checker u_ssa_checker (.*);
